[src/assert_macros.svh]
// Assertion macros used by the matrix add/multiply sequencer.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/mam_pkg.sv]
// Package for the matrix add/multiply block: widths, codes, shared types.
// No dependencies; every other file but assert_macros.svh imports it.
package mam_pkg;

   // Sizing
   localparam int MAX_DIM     = 8;
   localparam int VALUE_WIDTH = 16;
   localparam int MEM_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(MEM_DEPTH);
   localparam int PROD_W      = 2 * VALUE_WIDTH;

   // Fixed field widths
   localparam int REQ_TYPE_W = 2;
   localparam int IDX_W      = 3;
   localparam int ELEM_W     = 16;
   localparam int OUT_W      = 35;
   localparam int DIM_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;

   // Request kinds (code 3 is ignored)
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE_A = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE_B = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_COMPUTE = 2'd2;

   // Operation modes
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_MUL = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COLS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_ROWS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } mam_state_type;

   typedef struct packed {
      logic [DIM_W-1:0] a_rows;
      logic [DIM_W-1:0] a_cols;
      logic [DIM_W-1:0] b_rows;
      logic [DIM_W-1:0] b_cols;
      logic             op_mode;
   } mam_cfg_type;

   // Element store write
   typedef struct packed {
      logic                          we_a;
      logic                          we_b;
      logic [ADDR_W-1:0]             addr;
      logic signed [VALUE_WIDTH-1:0] data;
   } mam_wr_type;

   // Sequencer to arithmetic unit
   typedef struct packed {
      logic              issue;
      logic              first;
      logic              mode;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } mam_ctl_type;

   function automatic logic [ADDR_W-1:0] addr_of(logic [IDX_W-1:0] row,
                                                 logic [IDX_W-1:0] col);
      return ADDR_W'(int'(row) * MAX_DIM + int'(col));
   endfunction

   function automatic logic in_range(logic [IDX_W-1:0] idx);
      return int'(idx) < MAX_DIM;
   endfunction

   function automatic logic dim_ok(logic [DIM_W-1:0] d);
      return (d != '0) && (int'(d) <= MAX_DIM);
   endfunction

endpackage

[src/mam_req_if.sv]
// Request channel: valid/ready plus the element write or compute payload.
// Depends on mam_pkg.
interface mam_req_if import mam_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic [REQ_TYPE_W-1:0]    req_type;
   logic [IDX_W-1:0]         elem_row;
   logic [IDX_W-1:0]         elem_col;
   logic signed [ELEM_W-1:0] elem_value;

   modport source (output valid, req_type, elem_row, elem_col, elem_value,
                   input ready);
   modport sink (input valid, req_type, elem_row, elem_col, elem_value,
                 output ready);
endinterface

[src/mam_rsp_if.sv]
// Result channel: valid/ready plus one result element per item.
// Depends on mam_pkg.
interface mam_rsp_if import mam_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        out_row;
   logic [IDX_W-1:0]        out_col;
   logic signed [OUT_W-1:0] out_value;
   logic                    dim_error;
   logic                    is_last;

   modport source (output valid, out_row, out_col, out_value, dim_error, is_last,
                   input ready);
   modport sink (input valid, out_row, out_col, out_value, dim_error, is_last,
                 output ready);
endinterface

[src/mam_mac.sv]
// Element stores A and B and the shared multiply/add-accumulate unit.
// Depends on mam_pkg; driven by mam_seq through mam_ctl_type.
module mam_mac
   import mam_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mam_wr_type              wr,
   input  mam_ctl_type             ctl,
   output logic                    drained,
   output logic signed [OUT_W-1:0] acc
);

   logic signed [VALUE_WIDTH-1:0] mem_a [MEM_DEPTH];
   logic signed [VALUE_WIDTH-1:0] mem_b [MEM_DEPTH];

   logic signed [VALUE_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic                          v1_ff, v1_in, f1_ff, mode1_ff;
   logic                          v2_ff, v2_in, f2_ff;
   logic signed [OUT_W-1:0]       term_ff, term_in;
   logic signed [OUT_W-1:0]       acc_ff, acc_in;
   logic signed [PROD_W-1:0]      mul_w;
   logic signed [OUT_W-1:0]       sum_w;

   // Write on load, read with registered data on issue
   always_ff @(posedge clock) begin
      if (wr.we_a) begin
         mem_a[wr.addr] <= wr.data;
      end
      if (wr.we_b) begin
         mem_b[wr.addr] <= wr.data;
      end
      rd_a_ff  <= mem_a[ctl.addr_a];
      rd_b_ff  <= mem_b[ctl.addr_b];
      f1_ff    <= ctl.first;
      mode1_ff <= ctl.mode;
      f2_ff    <= f1_ff;
      term_ff  <= term_in;
      acc_ff   <= acc_in;
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // Form one term (product or sum), then fold it into the accumulator
   always_comb begin
      v1_in   = ctl.issue;
      v2_in   = v1_ff;
      mul_w   = rd_a_ff * rd_b_ff;
      sum_w   = OUT_W'(rd_a_ff) + OUT_W'(rd_b_ff);
      term_in = (mode1_ff == OP_MUL) ? OUT_W'(mul_w) : sum_w;
      acc_in  = acc_ff;
      if (v2_ff) begin
         acc_in = f2_ff ? term_ff : acc_ff + term_ff;
      end
   end

   assign drained = !v1_ff && !v2_ff;
   assign acc     = acc_ff;

endmodule

[src/mam_seq.sv]
// Sequencer: walks result elements and dot-product steps, holds the result register.
// Depends on mam_pkg, assert_macros.svh and mam_rsp_if.
`include "assert_macros.svh"

module mam_seq
   import mam_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mam_cfg_type             cfg,
   input  logic                    start,
   output logic                    idle,
   output mam_ctl_type             ctl,
   input  logic                    drained,
   input  logic signed [OUT_W-1:0] acc,
   mam_rsp_if.source               rsp_chan
);

   mam_state_type           state_ff, state_in;
   logic [IDX_W-1:0]        i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                    err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic signed [OUT_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_err_ff, rsp_err_in, rsp_last_ff, rsp_last_in;

   logic             mul;
   logic             cfg_ok;
   logic [DIM_W-1:0] nc;
   logic             i_last, j_last, k_last;
   logic             out_free;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Counters and result payload
   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      err_ff       <= err_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Dimension checks and loop bounds
   always_comb begin
      mul    = (cfg.op_mode == OP_MUL);
      cfg_ok = dim_ok(cfg.a_rows) && dim_ok(cfg.a_cols) &&
               dim_ok(cfg.b_rows) && dim_ok(cfg.b_cols);
      if (mul) begin
         cfg_ok = cfg_ok && (cfg.a_cols == cfg.b_rows);
      end else begin
         cfg_ok = cfg_ok && (cfg.a_rows == cfg.b_rows) && (cfg.a_cols == cfg.b_cols);
      end
      nc       = mul ? cfg.b_cols : cfg.a_cols;
      i_last   = (DIM_W'(i_ff) == cfg.a_rows - DIM_W'(1));
      j_last   = (DIM_W'(j_ff) == nc - DIM_W'(1));
      k_last   = !mul || (DIM_W'(k_ff) == cfg.b_rows - DIM_W'(1));
      out_free = !rsp_valid_ff || rsp_chan.ready;
   end

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      ctl.issue    = 1'b0;
      ctl.first    = (k_ff == '0);
      ctl.mode     = cfg.op_mode;
      ctl.addr_a   = mul ? addr_of(i_ff, k_ff) : addr_of(i_ff, j_ff);
      ctl.addr_b   = mul ? addr_of(k_ff, j_ff) : addr_of(i_ff, j_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               err_in   = !cfg_ok;
               state_in = cfg_ok ? ST_ISSUE : ST_EMIT;
            end
         end
         ST_ISSUE: begin
            ctl.issue = 1'b1;
            if (k_last) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (drained) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = err_ff ? '0 : i_ff;
               rsp_col_in   = err_ff ? '0 : j_ff;
               rsp_value_in = err_ff ? '0 : acc;
               rsp_err_in   = err_ff;
               rsp_last_in  = err_ff || (i_last && j_last);
               if (err_ff || (i_last && j_last)) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = '0;
                  state_in = ST_ISSUE;
                  if (j_last) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign idle               = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_row   = rsp_row_ff;
   assign rsp_chan.out_col   = rsp_col_ff;
   assign rsp_chan.out_value = rsp_value_ff;
   assign rsp_chan.dim_error = rsp_err_ff;
   assign rsp_chan.is_last   = rsp_last_ff;

   `ASSERT_ALWAYS(a_emit_drained, (state_ff == ST_EMIT) |-> drained, "emit before accumulator settled")
   `ASSERT_ALWAYS(a_err_alone, (rsp_valid_ff && rsp_err_ff) |-> (rsp_last_ff && rsp_value_ff == '0), "error item not final or nonzero")
   `ASSERT_NEXT(a_last_idle, (state_ff == ST_EMIT) && out_free && rsp_last_in, state_ff == ST_IDLE, "sequencer kept running after last item")

endmodule

[src/matrix_add_multiply.sv]
// Top level of the matrix add/multiply block: registers, request decode, submodules.
// Depends on mam_pkg, mam_req_if, mam_rsp_if, mam_mac and mam_seq.
//
//   Port       Dir  Protocol        Carries
//   req_chan   in   valid/ready     element write to A or B, or compute request
//   rsp_chan   out  valid/ready     one result element, error flag, last flag
//   csr_*      in   write enable    a_rows, a_cols, b_rows, b_cols, op_mode
//
// A compute request holds req ready low while it runs: for each result element the sequencer
// issues K steps, K = b_rows in multiply mode and 1 in add mode, through the store read,
// the shared multiply/add stage and the accumulator, then drains and emits the element.
// A dimension error sends the sequencer straight to its emit step for one item.
// Synchronous reset clears the registers to 1 by 1 add mode; stores are not cleared.
// A stalled result holds the sequencer in its emit step; one item can wait in the output.
module matrix_add_multiply
   import mam_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mam_req_if.sink               req_chan,
   mam_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   mam_cfg_type             cfg_ff, cfg_in;
   mam_wr_type              wr;
   mam_ctl_type             ctl;
   logic                    idle;
   logic                    accept;
   logic                    start;
   logic                    drained;
   logic signed [OUT_W-1:0] acc;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.a_rows  <= DIM_W'(1);
         cfg_ff.a_cols  <= DIM_W'(1);
         cfg_ff.b_rows  <= DIM_W'(1);
         cfg_ff.b_cols  <= DIM_W'(1);
         cfg_ff.op_mode <= OP_ADD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Decode register writes; drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_A_ROWS:  cfg_in.a_rows  = csr_wdata;
            CSR_A_COLS:  cfg_in.a_cols  = csr_wdata;
            CSR_B_ROWS:  cfg_in.b_rows  = csr_wdata;
            CSR_B_COLS:  cfg_in.b_cols  = csr_wdata;
            CSR_OP_MODE: cfg_in.op_mode = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Decode accepted items into store writes or a compute start
   always_comb begin
      accept   = req_chan.valid && idle;
      start    = accept && (req_chan.req_type == REQ_COMPUTE);
      wr.addr  = addr_of(req_chan.elem_row, req_chan.elem_col);
      wr.data  = VALUE_WIDTH'(req_chan.elem_value);
      wr.we_a  = accept && (req_chan.req_type == REQ_WRITE_A) &&
                 in_range(req_chan.elem_row) && in_range(req_chan.elem_col);
      wr.we_b  = accept && (req_chan.req_type == REQ_WRITE_B) &&
                 in_range(req_chan.elem_row) && in_range(req_chan.elem_col);
   end

   assign req_chan.ready = idle;

   mam_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .start    (start),
      .idle     (idle),
      .ctl      (ctl),
      .drained  (drained),
      .acc      (acc),
      .rsp_chan (rsp_chan)
   );

   mam_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .ctl     (ctl),
      .drained (drained),
      .acc     (acc)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for matrix_add_multiply: element loads into A and B, add and multiply requests,
// dimension errors and register decode, checked against an in-bench matrix predictor.
// Depends on mam_pkg, mam_req_if, mam_rsp_if and the matrix_add_multiply RTL.
module tb;
   import mam_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;
   localparam int RANDOM_ITEMS  = 170;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_CYCLES  = 30;
   localparam int QUIET_LIMIT   = 4000;

   typedef struct {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [OUT_W-1:0] value;
      logic                    dim_error;
      logic                    is_last;
   } matrix_elem_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mam_req_if req_if ();
   mam_rsp_if rsp_if ();

   // Predictor copy of the element stores, their load flags and the shape registers
   logic signed [VALUE_WIDTH-1:0] a_elems [MEM_DEPTH];
   logic signed [VALUE_WIDTH-1:0] b_elems [MEM_DEPTH];
   bit                            a_loaded [MEM_DEPTH];
   bit                            b_loaded [MEM_DEPTH];
   mam_cfg_type                   shape_cfg;
   matrix_elem_type               pending_elems [$];

   int unsigned mismatch_count;
   int unsigned items_sent;
   bit          req_throttle;
   bit          rsp_throttle;

   matrix_add_multiply i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned random_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Bias values toward the extremes of the signed range and toward zero and minus one
   function automatic logic signed [ELEM_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return ELEM_MIN;
         1: return ELEM_MAX;
         2: return '0;
         3: return '1;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] random_dim();
      if ($urandom_range(0, 9) < 8) return DIM_W'($urandom_range(1, 3));
      return DIM_W'($urandom_range(4, MAX_DIM));
   endfunction

   function automatic bit dim_in_bounds(input logic [DIM_W-1:0] d);
      return (d >= 1) && (int'(d) <= MAX_DIM);
   endfunction

   function automatic bit shape_legal();
      if (!(dim_in_bounds(shape_cfg.a_rows) && dim_in_bounds(shape_cfg.a_cols) &&
            dim_in_bounds(shape_cfg.b_rows) && dim_in_bounds(shape_cfg.b_cols)))
         return 1'b0;
      if (shape_cfg.op_mode == OP_ADD)
         return (shape_cfg.a_rows == shape_cfg.b_rows) && (shape_cfg.a_cols == shape_cfg.b_cols);
      return shape_cfg.a_cols == shape_cfg.b_rows;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_A_ROWS:  shape_cfg.a_rows  = data;
         CSR_A_COLS:  shape_cfg.a_cols  = data;
         CSR_B_ROWS:  shape_cfg.b_rows  = data;
         CSR_B_COLS:  shape_cfg.b_cols  = data;
         CSR_OP_MODE: shape_cfg.op_mode = data[0];
         default: ;
      endcase
   endfunction

   // Update the stores on a load; queue the result elements of a compute request
   function automatic void predict_matrix_op(input logic [REQ_TYPE_W-1:0] kind,
                                             input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col,
                                             input logic signed [ELEM_W-1:0] value);
      int unsigned     addr;
      int              n_rows;
      int              n_cols;
      longint          acc;
      matrix_elem_type elem;
      addr = int'(row) * MAX_DIM + int'(col);
      case (kind)
         REQ_WRITE_A: begin
            a_elems[addr]  = VALUE_WIDTH'(value);
            a_loaded[addr] = 1'b1;
         end
         REQ_WRITE_B: begin
            b_elems[addr]  = VALUE_WIDTH'(value);
            b_loaded[addr] = 1'b1;
         end
         REQ_COMPUTE: begin
            if (!shape_legal()) begin
               elem.row       = '0;
               elem.col       = '0;
               elem.value     = '0;
               elem.dim_error = 1'b1;
               elem.is_last   = 1'b1;
               pending_elems.push_back(elem);
            end else begin
               n_rows = int'(shape_cfg.a_rows);
               n_cols = (shape_cfg.op_mode == OP_ADD) ? int'(shape_cfg.a_cols)
                                                      : int'(shape_cfg.b_cols);
               for (int i = 0; i < n_rows; i++) begin
                  for (int j = 0; j < n_cols; j++) begin
                     acc = 0;
                     if (shape_cfg.op_mode == OP_ADD) begin
                        acc = longint'(a_elems[i*MAX_DIM+j]) + longint'(b_elems[i*MAX_DIM+j]);
                     end else begin
                        for (int k = 0; k < int'(shape_cfg.b_rows); k++)
                           acc += longint'(a_elems[i*MAX_DIM+k]) *
                                  longint'(b_elems[k*MAX_DIM+j]);
                     end
                     elem.row       = IDX_W'(i);
                     elem.col       = IDX_W'(j);
                     elem.value     = OUT_W'(acc);
                     elem.dim_error = 1'b0;
                     elem.is_last   = (i == n_rows - 1) && (j == n_cols - 1);
                     pending_elems.push_back(elem);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // Send one item, with an optional gap first; valid stays high afterwards
   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                               input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col,
                               input logic signed [ELEM_W-1:0] value);
      int unsigned gap;
      gap = req_throttle ? random_gap() : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      = 1'b1;
      req_if.req_type   = kind;
      req_if.elem_row   = row;
      req_if.elem_col   = col;
      req_if.elem_value = value;
      do @(posedge clock); while (!req_if.ready);
      predict_matrix_op(kind, row, col, value);
      if (kind != REQ_UNUSED) items_sent++;
   endtask

   task automatic send_compute();
      send_request(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), random_value());
   endtask

   task automatic send_random_load();
      int unsigned               pick;
      logic [REQ_TYPE_W-1:0]     kind;
      pick = $urandom_range(0, 9);
      kind = (pick == 0) ? REQ_UNUSED : (pick < 5) ? REQ_WRITE_A : REQ_WRITE_B;
      send_request(kind, IDX_W'($urandom_range(0, MAX_DIM-1)),
                   IDX_W'($urandom_range(0, MAX_DIM-1)), random_value());
   endtask

   // Drop valid, drain every expected element, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      apply_csr(index, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_shape(input logic [DIM_W-1:0] a_rows, input logic [DIM_W-1:0] a_cols,
                            input logic [DIM_W-1:0] b_rows, input logic [DIM_W-1:0] b_cols,
                            input logic [CSR_DATA_W-1:0] mode_word);
      write_csr(CSR_A_ROWS, a_rows);
      write_csr(CSR_A_COLS, a_cols);
      write_csr(CSR_B_ROWS, b_rows);
      write_csr(CSR_B_COLS, b_cols);
      write_csr(CSR_OP_MODE, mode_word);
   endtask

   // Load every element the next compute reads that has not been loaded yet
   task automatic load_operands();
      if (!shape_legal()) return;
      for (int i = 0; i < int'(shape_cfg.a_rows); i++)
         for (int j = 0; j < int'(shape_cfg.a_cols); j++)
            if (!a_loaded[i*MAX_DIM+j])
               send_request(REQ_WRITE_A, IDX_W'(i), IDX_W'(j), random_value());
      for (int i = 0; i < int'(shape_cfg.b_rows); i++)
         for (int j = 0; j < int'(shape_cfg.b_cols); j++)
            if (!b_loaded[i*MAX_DIM+j])
               send_request(REQ_WRITE_B, IDX_W'(i), IDX_W'(j), random_value());
   endtask

   // Reset shape is 1 by 1 add; extremes of the value range, an ignored request type
   task automatic test_single_element();
      send_request(REQ_WRITE_A, '0, '0, ELEM_MAX);
      send_request(REQ_WRITE_B, '0, '0, ELEM_MAX);
      send_compute();
      send_request(REQ_UNUSED, '1, '1, '1);
      send_request(REQ_WRITE_A, '0, '0, ELEM_MIN);
      send_request(REQ_WRITE_B, '0, '0, ELEM_MIN);
      send_compute();
      wait_idle();
      // upper data bits of the mode register are dropped
      write_csr(CSR_OP_MODE, '1);
      send_compute();
   endtask

   // Writes to indexes past the register list leave the shape alone
   task automatic test_register_decode();
      wait_idle();
      set_shape(1, 1, 1, 1, CSR_DATA_W'(OP_ADD));
      for (int idx = int'(CSR_OP_MODE) + 1; idx < 2**CSR_IDX_W; idx++)
         write_csr(CSR_IDX_W'(idx), '1);
      send_compute();
   endtask

   task automatic test_dim_errors();
      wait_idle();
      set_shape(2, 1, 1, 1, CSR_DATA_W'(OP_ADD));
      send_compute();
      wait_idle();
      set_shape(0, 1, 0, 1, CSR_DATA_W'(OP_ADD));
      send_compute();
      wait_idle();
      set_shape(9, 1, 9, 1, CSR_DATA_W'(OP_ADD));
      send_compute();
      wait_idle();
      set_shape(1, 15, 15, 1, CSR_DATA_W'(OP_MUL));
      send_compute();
      wait_idle();
      set_shape(2, 3, 2, 2, CSR_DATA_W'(OP_MUL));
      send_compute();
   endtask

   // Longest dot product with the most negative value gives the largest result
   task automatic test_long_dot_product();
      wait_idle();
      set_shape(1, DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), 1, CSR_DATA_W'(OP_MUL));
      for (int k = 0; k < MAX_DIM; k++) begin
         send_request(REQ_WRITE_A, '0, IDX_W'(k), ELEM_MIN);
         send_request(REQ_WRITE_B, IDX_W'(k), '0, ELEM_MIN);
      end
      send_compute();
   endtask

   // One shape per phase: loads with random content, then one or two computes
   task automatic run_random_phase(input bit full_outer);
      logic [DIM_W-1:0]      ar, ac, br, bc;
      logic                  mode;
      logic [CSR_DATA_W-1:0] mode_word;
      int unsigned           n_loads;
      int unsigned           n_computes;
      wait_idle();
      mode = 1'($urandom_range(0, 1));
      if (full_outer) begin
         mode = OP_MUL;
         ar = DIM_W'(MAX_DIM);
         ac = DIM_W'(1);
         br = DIM_W'(1);
         bc = DIM_W'(MAX_DIM);
      end else if ($urandom_range(0, 9) == 0) begin
         ar = DIM_W'($urandom);
         ac = DIM_W'($urandom);
         br = DIM_W'($urandom);
         bc = DIM_W'($urandom);
      end else begin
         ar = random_dim();
         ac = random_dim();
         br = (mode == OP_ADD) ? ar : ac;
         bc = (mode == OP_ADD) ? ac : random_dim();
      end
      mode_word    = CSR_DATA_W'($urandom);
      mode_word[0] = mode;
      set_shape(ar, ac, br, bc, mode_word);
      if ($urandom_range(0, 4) == 0)
         write_csr(CSR_IDX_W'($urandom_range(int'(CSR_OP_MODE) + 1, 2**CSR_IDX_W - 1)),
                   CSR_DATA_W'($urandom));
      req_throttle = $urandom_range(0, 3) != 0;
      rsp_throttle = $urandom_range(0, 3) != 0;
      n_loads = $urandom_range(0, 6);
      repeat (n_loads) send_random_load();
      load_operands();
      n_computes = $urandom_range(1, 2);
      for (int c = 0; c < int'(n_computes); c++) begin
         if (c != 0) repeat ($urandom_range(0, 2)) send_random_load();
         send_compute();
      end
   endtask

   task automatic test_random_traffic();
      items_sent = 0;
      run_random_phase(1'b1);
      while (items_sent < RANDOM_ITEMS) run_random_phase(1'b0);
   endtask

   // Result ready with random stalls
   initial begin
      int unsigned stall;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = rsp_throttle ? random_gap() : 0;
         if (stall != 0) begin
            rsp_if.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
      end
   end

   // Compare each accepted result with the oldest expected element
   always @(posedge clock) begin : result_check
      matrix_elem_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_elems.size() == 0) begin
            report_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                      rsp_if.out_row, rsp_if.out_col, rsp_if.out_value));
         end else begin
            want = pending_elems.pop_front();
            if (rsp_if.out_row !== want.row)
               report_mismatch($sformatf("out_row %0d, expected %0d",
                                         rsp_if.out_row, want.row));
            if (rsp_if.out_col !== want.col)
               report_mismatch($sformatf("out_col %0d, expected %0d",
                                         rsp_if.out_col, want.col));
            if (rsp_if.out_value !== want.value)
               report_mismatch($sformatf("out_value %0d at (%0d,%0d), expected %0d",
                                         rsp_if.out_value, want.row, want.col, want.value));
            if (rsp_if.dim_error !== want.dim_error)
               report_mismatch($sformatf("dim_error %b, expected %b",
                                         rsp_if.dim_error, want.dim_error));
            if (rsp_if.is_last !== want.is_last)
               report_mismatch($sformatf("is_last %b at (%0d,%0d), expected %b",
                                         rsp_if.is_last, want.row, want.col, want.is_last));
         end
      end
   end

   // End the run when nothing has moved for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("matrix_add_multiply test failed");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.req_type   = REQ_WRITE_A;
      req_if.elem_row   = '0;
      req_if.elem_col   = '0;
      req_if.elem_value = '0;
      shape_cfg         = '{a_rows: 4'd1, a_cols: 4'd1, b_rows: 4'd1, b_cols: 4'd1,
                            op_mode: OP_ADD};
      mismatch_count    = 0;
      items_sent        = 0;
      req_throttle      = 1'b0;
      rsp_throttle      = 1'b0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_single_element();
      test_register_decode();
      test_dim_errors();
      test_long_dot_product();
      test_random_traffic();

      // Drain, then watch for stray results
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("matrix_add_multiply test passed");
      else
         $display("matrix_add_multiply test failed");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/mam_pkg.sv
src/mam_req_if.sv
src/mam_rsp_if.sv
src/mam_mac.sv
src/mam_seq.sv
src/matrix_add_multiply.sv
tb/tb.sv
